// ----- hw/rtl/hrlp_pkg.sv -----
`default_nettype none
package hrlp_pkg;

    // Line length limit in bytes; the byte that brings the count to this value is dropped.
    localparam int LINE_BYTES = 64;
    localparam int CNT_W      = $clog2(LINE_BYTES);

    localparam int CHAR_W  = 8;
    localparam int INDEX_W = 6;
    localparam int KIND_W  = 3;
    localparam int OUT_W   = 16;

    localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;
    localparam logic [CHAR_W-1:0] CHAR_LF    = 8'h0A;
    localparam logic [CHAR_W-1:0] CHAR_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CHAR_COLON = 8'h3A;
    localparam logic [CHAR_W-1:0] CHAR_0     = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_9     = 8'h39;
    localparam logic [CHAR_W-1:0] CHAR_UA    = 8'h41;
    localparam logic [CHAR_W-1:0] CHAR_UZ    = 8'h5A;
    localparam logic [CHAR_W-1:0] CHAR_LA    = 8'h61;
    localparam logic [CHAR_W-1:0] CHAR_LF_HEX = 8'h66;
    localparam logic [CHAR_W-1:0] LOWER_OFS  = 8'd87;
    localparam logic [CHAR_W-1:0] CASE_OFS   = 8'd32;

    typedef enum logic [KIND_W-1:0] {
        KIND_DATA     = 3'd0,
        KIND_OK       = 3'd1,
        KIND_CSUM     = 3'd2,
        KIND_LONG     = 3'd3,
        KIND_EOF      = 3'd4,
        KIND_EOF_LINE = 3'd5
    } kind_t;

    function automatic logic [CHAR_W-1:0] fold_lower(input logic [CHAR_W-1:0] c);
        logic [CHAR_W-1:0] r;
        r = c;
        if (c >= CHAR_UA && c <= CHAR_UZ)
            r = c + CASE_OFS;
        return r;
    endfunction

    // Non-hex characters decode as nibble 0.
    function automatic logic [3:0] nibble_of(input logic [CHAR_W-1:0] c);
        logic [CHAR_W-1:0] d;
        d = '0;
        if (c >= CHAR_0 && c <= CHAR_9)
            d = c - CHAR_0;
        else if (c >= CHAR_LA && c <= CHAR_LF_HEX)
            d = c - LOWER_OFS;
        return d[3:0];
    endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/hex_record_line_parser.sv -----
// The input register captures each character; its result is then written to the
// result register, which drives the master side.
// Throughput: one character per cycle while the output is not stalled; the input
// register advances whenever the result register is empty or being drained, so a
// stall on the output holds at most one item in each register.
// Reset: asynchronous, active low; clears both valid flags and returns the
// parser to hunting for a colon with an empty sum and byte count.
`default_nettype none
module hex_record_line_parser (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_axis_tvalid,
    output      logic                          s_axis_tready,
    input  wire logic [hrlp_pkg::CHAR_W-1:0]   s_axis_tdata,   // [7:0] character
    output      logic                          m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    output      logic [hrlp_pkg::OUT_W-1:0]    m_axis_tdata,   // [7:0] data_byte,
                                                               // [13:8] byte_index,
                                                               // [15:14] zero
    output      logic [hrlp_pkg::KIND_W-1:0]   m_axis_tuser    // [2:0] kind
);
    import hrlp_pkg::*;

    // Input register
    logic              in_valid_reg;
    logic [CHAR_W-1:0] in_char_reg;

    // Result register
    logic               out_valid_reg,  out_valid_next;
    kind_t              out_kind_reg,   out_kind_next;
    logic [7:0]         out_byte_reg,   out_byte_next;
    logic [INDEX_W-1:0] out_index_reg,  out_index_next;

    // Parser state
    logic             inside_reg,  inside_next;
    logic             have_hi_reg, have_hi_next;
    logic [3:0]       hi_nib_reg,  hi_nib_next;
    logic [7:0]       sum_reg,     sum_next;
    logic [CNT_W-1:0] count_reg,   count_next;

    logic              out_free;
    logic              advance;
    logic [CHAR_W-1:0] c_low;
    logic [7:0]        byte_val;

    // The result slot is free when empty or when its item leaves this cycle.
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign advance       = in_valid_reg && out_free;
    assign s_axis_tready = !in_valid_reg || out_free;

    assign c_low    = fold_lower(in_char_reg);
    assign byte_val = {hi_nib_reg, nibble_of(c_low)};

    always_comb
    begin
        inside_next    = inside_reg;
        have_hi_next   = have_hi_reg;
        hi_nib_next    = hi_nib_reg;
        sum_next       = sum_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_kind_next  = out_kind_reg;
        out_byte_next  = out_byte_reg;
        out_index_next = out_index_reg;

        if (advance)
        begin
            if (!inside_reg)
            begin
                // Hunt: zero means end of file, colon opens a line, drop the rest.
                if (in_char_reg == CHAR_NUL)
                begin
                    out_valid_next = 1'b1;
                    out_kind_next  = KIND_EOF;
                    out_byte_next  = '0;
                    out_index_next = '0;
                end
                else if (in_char_reg == CHAR_COLON)
                begin
                    inside_next  = 1'b1;
                    have_hi_next = 1'b0;
                    hi_nib_next  = '0;
                    sum_next     = '0;
                    count_next   = '0;
                end
            end
            else if (c_low == CHAR_NUL)
            begin
                // End of file inside a line: flag it and go back to hunting.
                inside_next    = 1'b0;
                have_hi_next   = 1'b0;
                hi_nib_next    = '0;
                sum_next       = '0;
                count_next     = '0;
                out_valid_next = 1'b1;
                out_kind_next  = KIND_EOF_LINE;
                out_byte_next  = '0;
                out_index_next = '0;
            end
            else if (!have_hi_reg)
            begin
                if (c_low == CHAR_LF || c_low == CHAR_CR)
                begin
                    inside_next    = 1'b0;
                    have_hi_next   = 1'b0;
                    hi_nib_next    = '0;
                    sum_next       = '0;
                    count_next     = '0;
                    out_valid_next = 1'b1;
                    out_kind_next  = (sum_reg == 8'd0) ? KIND_OK : KIND_CSUM;
                    out_byte_next  = '0;
                    out_index_next = '0;
                end
                else
                begin
                    hi_nib_next  = nibble_of(c_low);
                    have_hi_next = 1'b1;
                end
            end
            else if (count_reg == CNT_W'(LINE_BYTES - 1))
            begin
                // Byte that fills the line: drop it and report the long line.
                inside_next    = 1'b0;
                have_hi_next   = 1'b0;
                hi_nib_next    = '0;
                sum_next       = '0;
                count_next     = '0;
                out_valid_next = 1'b1;
                out_kind_next  = KIND_LONG;
                out_byte_next  = '0;
                out_index_next = '0;
            end
            else
            begin
                sum_next       = sum_reg + byte_val;
                have_hi_next   = 1'b0;
                hi_nib_next    = '0;
                count_next     = count_reg + CNT_W'(1);
                out_valid_next = 1'b1;
                out_kind_next  = KIND_DATA;
                out_byte_next  = byte_val;
                out_index_next = INDEX_W'(count_reg);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            inside_reg    <= 1'b0;
            have_hi_reg   <= 1'b0;
            hi_nib_reg    <= '0;
            sum_reg       <= '0;
            count_reg     <= '0;
        end
        else
        begin
            if (s_axis_tready)
                in_valid_reg <= s_axis_tvalid;
            out_valid_reg <= out_valid_next;
            inside_reg    <= inside_next;
            have_hi_reg   <= have_hi_next;
            hi_nib_reg    <= hi_nib_next;
            sum_reg       <= sum_next;
            count_reg     <= count_next;
        end
    end

    // Payload registers: no reset needed.
    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
            in_char_reg <= s_axis_tdata;
        out_kind_reg  <= out_kind_next;
        out_byte_reg  <= out_byte_next;
        out_index_reg <= out_index_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {(OUT_W - 8 - INDEX_W)'(0), out_index_reg, out_byte_reg};
    assign m_axis_tuser  = out_kind_reg;

endmodule
`default_nettype wire
